@@ rtl/bfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Bernoulli function pair: shared package
// Command and status types between controller and datapath, region codes,
// the fixed work format and the reciprocal table used by the divide-by-index.
// ----------------------------------------------------------------------------
package bfp_pkg;

   // Work format is unsigned Q.30.
   localparam int WF = 30;

   // ln(2) in the work format.
   localparam logic [36:0] LN2_W = 37'd744261118;

   typedef enum logic [1:0] {
      REG_ZERO   = 2'd0,
      REG_ASYM   = 2'd1,
      REG_DIRECT = 2'd2,
      REG_SERIES = 2'd3
   } region_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_RED,
      OP_MUL,
      OP_RCP,
      OP_FIX,
      OP_ACC,
      OP_EXPF,
      OP_DIVA,
      OP_DIVC,
      OP_DSTEP,
      OP_FIN_DIR,
      OP_FIN_SER,
      OP_WRITE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] bit_sel;   // quotient bit for range reduction
      logic [4:0] idx_m1;    // term index minus one
   } cmd_type;

   typedef struct packed {
      region_type region;
      logic       term_zero;
      logic       term_gt_thr;
   } status_type;

   // Last term index (minus one) for the exponential and the series loops.
   localparam logic [4:0] DIR_LAST_M1 = 5'd23;
   localparam logic [4:0] SER_LAST_M1 = 5'd31;

   // floor((2^32-1)/i) for i = 1..32; the product with it is at most one low.
   localparam logic [31:0] RECIP_TBL [32] = '{
      32'(64'hFFFFFFFF / 64'd1),  32'(64'hFFFFFFFF / 64'd2),
      32'(64'hFFFFFFFF / 64'd3),  32'(64'hFFFFFFFF / 64'd4),
      32'(64'hFFFFFFFF / 64'd5),  32'(64'hFFFFFFFF / 64'd6),
      32'(64'hFFFFFFFF / 64'd7),  32'(64'hFFFFFFFF / 64'd8),
      32'(64'hFFFFFFFF / 64'd9),  32'(64'hFFFFFFFF / 64'd10),
      32'(64'hFFFFFFFF / 64'd11), 32'(64'hFFFFFFFF / 64'd12),
      32'(64'hFFFFFFFF / 64'd13), 32'(64'hFFFFFFFF / 64'd14),
      32'(64'hFFFFFFFF / 64'd15), 32'(64'hFFFFFFFF / 64'd16),
      32'(64'hFFFFFFFF / 64'd17), 32'(64'hFFFFFFFF / 64'd18),
      32'(64'hFFFFFFFF / 64'd19), 32'(64'hFFFFFFFF / 64'd20),
      32'(64'hFFFFFFFF / 64'd21), 32'(64'hFFFFFFFF / 64'd22),
      32'(64'hFFFFFFFF / 64'd23), 32'(64'hFFFFFFFF / 64'd24),
      32'(64'hFFFFFFFF / 64'd25), 32'(64'hFFFFFFFF / 64'd26),
      32'(64'hFFFFFFFF / 64'd27), 32'(64'hFFFFFFFF / 64'd28),
      32'(64'hFFFFFFFF / 64'd29), 32'(64'hFFFFFFFF / 64'd30),
      32'(64'hFFFFFFFF / 64'd31), 32'(64'hFFFFFFFF / 64'd32)
   };

endpackage

@@ rtl/bfp_dp.sv @@
// ----------------------------------------------------------------------------
// Bernoulli function pair: datapath
// Classification, range reduction, shared term unit (multiply, divide by
// index), accumulators, a radix-2 restoring divider and the result register.
// ----------------------------------------------------------------------------
module bfp_dp #(
   parameter int FRAC_BITS = 16,
   parameter int INT_BITS  = 8
) (
   input  logic                             clock,
   input  logic signed [INT_BITS+FRAC_BITS:0] arg,
   input  bfp_pkg::cmd_type                 cmd,
   output bfp_pkg::status_type              status,
   output logic [INT_BITS+FRAC_BITS-1:0]    b_pos,
   output logic [INT_BITS+FRAC_BITS-1:0]    b_neg,
   output logic [1:0]                       region
);
   import bfp_pkg::*;

   localparam int OUT_W = INT_BITS + FRAC_BITS;
   localparam int IN_W  = OUT_W + 1;
   localparam int DNW   = OUT_W + 31;
   localparam int AW    = 37;
   localparam int UP    = (FRAC_BITS <= WF) ? (WF - FRAC_BITS) : 0;
   localparam int DN    = (FRAC_BITS > WF) ? (FRAC_BITS - WF) : 0;
   localparam int TSH   = (FRAC_BITS < WF) ? (WF - FRAC_BITS) : 0;
   localparam logic [30:0] THR = (FRAC_BITS < WF) ? (31'(1) << TSH) : 31'(0);
   localparam logic [30:0] ONE_W = 31'(1) << WF;
   localparam logic signed [32:0] ONE_S = 33'sd1073741824;
   localparam logic [IN_W-1:0] BIG_LIM = IN_W'(80) << FRAC_BITS;
   localparam logic [IN_W-1:0] SMALL_LIM = IN_W'((64'd1 << FRAC_BITS) / 64'd100);
   localparam logic [OUT_W-1:0] OUT_MAX = '1;
   localparam logic [OUT_W-1:0] ONE_OUT = OUT_W'(1) << FRAC_BITS;
   localparam logic [DNW-1:0] ONE_DIV = DNW'(1) << (WF + FRAC_BITS);

   function automatic logic [OUT_W-1:0] sat_out(input logic [DNW-1:0] v);
      sat_out = (v > DNW'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
   endfunction

   logic [IN_W-1:0]   k_ff;
   logic              neg_ff;
   region_type        region_ff;
   logic [AW-1:0]     r_ff;
   logic [6:0]        n_ff;
   logic [30:0]       term_ff, prod_ff, quo_ff;
   logic [31:0]       acc_a_ff;
   logic signed [32:0] acc_c_ff;
   logic [31:0]       den_ff, rem_ff;
   logic [DNW-1:0]    nq_ff;
   logic [OUT_W-1:0]  res_a_ff, res_p_ff, res_n_ff;
   logic [OUT_W-1:0]  out_pos_ff, out_neg_ff;
   region_type        out_reg_ff;

   logic [IN_W-1:0]   arg_u, mag;
   logic [IN_W+29:0]  wk;
   logic [AW-1:0]     a_w, red_cmp;
   region_type        cls;
   logic [60:0]       mprod;
   logic [62:0]       rprod;
   logic [5:0]        idx_w;
   logic [36:0]       back, rem_t;
   logic [30:0]       term_fix, s_cl, t_exp;
   logic [31:0]       dden, csd;
   logic              odd_i, sub_c;
   logic [32:0]       rem2;
   logic              ge;
   logic [DNW:0]      big_w;
   logic [DNW-1:0]    big, sml;

   always_comb begin
      arg_u = arg;
      mag   = arg_u[IN_W-1] ? (~arg_u + 1'b1) : arg_u;
      wk    = (IN_W + 30)'(mag) << UP;
      a_w   = AW'(wk >> DN);
      if (mag == '0) begin
         cls = REG_ZERO;
      end else if (mag > BIG_LIM) begin
         cls = REG_ASYM;
      end else if (mag > SMALL_LIM) begin
         cls = REG_DIRECT;
      end else begin
         cls = REG_SERIES;
      end

      red_cmp = LN2_W << cmd.bit_sel;
      mprod   = 61'(term_ff) * 61'(r_ff[29:0]);
      rprod   = 63'(prod_ff) * 63'(RECIP_TBL[cmd.idx_m1]);
      idx_w   = 6'(cmd.idx_m1) + 6'd1;
      back    = 37'(quo_ff) * 37'(idx_w);
      rem_t   = 37'(prod_ff) - back;
      term_fix = (rem_t >= 37'(idx_w)) ? quo_ff + 31'd1 : quo_ff;

      // Term index i is odd when idx_m1 is even.
      odd_i = !cmd.idx_m1[0];
      sub_c = (region_ff == REG_DIRECT) ? odd_i : !odd_i;

      if (acc_c_ff < 0) begin
         s_cl = '0;
      end else if (acc_c_ff > ONE_S) begin
         s_cl = ONE_W;
      end else begin
         s_cl = acc_c_ff[30:0];
      end
      t_exp = s_cl >> n_ff;
      dden  = {1'b0, ONE_W} - 32'(t_exp);
      if (dden == '0) begin
         dden = 32'd1;
      end
      csd = (acc_c_ff < 33'sd1) ? 32'd1 : acc_c_ff[31:0];

      rem2 = {rem_ff, nq_ff[DNW-1]};
      ge   = rem2 >= {1'b0, den_ff};

      big_w = ((DNW + 1)'(nq_ff) + (DNW + 1)'(1)) >> 1;
      big   = big_w[DNW-1:0];
      sml   = (big >= DNW'(k_ff)) ? big - DNW'(k_ff) : '0;
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            k_ff      <= mag;
            neg_ff    <= arg_u[IN_W-1];
            region_ff <= cls;
            r_ff      <= a_w;
            n_ff      <= '0;
            term_ff   <= ONE_W;
            acc_a_ff  <= 32'(ONE_W);
            acc_c_ff  <= ONE_S;
         end
         OP_RED: begin
            if (r_ff >= red_cmp) begin
               r_ff <= r_ff - red_cmp;
               n_ff[cmd.bit_sel] <= 1'b1;
            end
         end
         OP_MUL: prod_ff <= mprod[60:30];
         OP_RCP: quo_ff  <= rprod[62:32];
         OP_FIX: term_ff <= term_fix;
         OP_ACC: begin
            acc_a_ff <= acc_a_ff + 32'(term_ff);
            if (sub_c) begin
               acc_c_ff <= acc_c_ff - $signed({2'b00, term_ff});
            end else begin
               acc_c_ff <= acc_c_ff + $signed({2'b00, term_ff});
            end
         end
         OP_EXPF: begin
            den_ff <= dden;
            nq_ff  <= DNW'(k_ff) << 31;
            rem_ff <= '0;
         end
         OP_DIVA: begin
            den_ff <= acc_a_ff;
            nq_ff  <= ONE_DIV + DNW'(acc_a_ff >> 1);
            rem_ff <= '0;
         end
         OP_DIVC: begin
            res_a_ff <= sat_out(nq_ff);
            den_ff   <= csd;
            nq_ff    <= ONE_DIV + DNW'(csd >> 1);
            rem_ff   <= '0;
         end
         OP_DSTEP: begin
            rem_ff <= ge ? 32'(rem2 - {1'b0, den_ff}) : rem2[31:0];
            nq_ff  <= {nq_ff[DNW-2:0], ge};
         end
         OP_FIN_DIR: begin
            res_p_ff <= neg_ff ? sat_out(big) : sat_out(sml);
            res_n_ff <= neg_ff ? sat_out(sml) : sat_out(big);
         end
         OP_FIN_SER: begin
            res_p_ff <= neg_ff ? sat_out(nq_ff) : res_a_ff;
            res_n_ff <= neg_ff ? res_a_ff : sat_out(nq_ff);
         end
         OP_WRITE: begin
            out_reg_ff <= region_ff;
            unique case (region_ff)
               REG_ZERO: begin
                  out_pos_ff <= ONE_OUT;
                  out_neg_ff <= ONE_OUT;
               end
               REG_ASYM: begin
                  out_pos_ff <= neg_ff ? sat_out(DNW'(k_ff)) : '0;
                  out_neg_ff <= neg_ff ? '0 : sat_out(DNW'(k_ff));
               end
               default: begin
                  out_pos_ff <= res_p_ff;
                  out_neg_ff <= res_n_ff;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   assign status.region      = region_ff;
   assign status.term_zero   = (term_ff == '0);
   assign status.term_gt_thr = (term_ff > THR);

   assign b_pos  = out_pos_ff;
   assign b_neg  = out_neg_ff;
   assign region = out_reg_ff;

endmodule

@@ rtl/bfp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bernoulli function pair: controller
// Sequences the datapath through classification, range reduction, the term
// loop, the divisions and the result write, and owns the result valid flag.
// ----------------------------------------------------------------------------
module bfp_ctrl #(
   parameter int DNW = 55
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  bfp_pkg::status_type status,
   output bfp_pkg::cmd_type    cmd
);
   import bfp_pkg::*;

   localparam int CW = $clog2(DNW);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLASS, ST_RED, ST_MUL, ST_RCP, ST_FIX, ST_ACC,
      ST_EXPF, ST_DIV, ST_POST, ST_OUT
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [4:0]    idx_ff, idx_in;
   logic          second_ff, second_in;
   logic          valid_ff, valid_in;
   logic          cont;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      second_in  = second_ff;
      valid_in   = valid_ff && !rsp_tready;
      req_tready = 1'b0;
      cont       = 1'b0;
      cmd.op      = OP_NOP;
      cmd.bit_sel = cnt_ff[2:0];
      cmd.idx_m1  = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_CLASS;
            end
         end
         ST_CLASS: begin
            unique case (status.region)
               REG_DIRECT: begin
                  cnt_in   = CW'(6);
                  idx_in   = '0;
                  state_in = ST_RED;
               end
               REG_SERIES: begin
                  // The series starts at the second term.
                  idx_in   = 5'd1;
                  state_in = ST_MUL;
               end
               default: state_in = ST_OUT;
            endcase
         end
         ST_RED: begin
            cmd.op = OP_RED;
            if (cnt_ff == '0) begin
               state_in = ST_MUL;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_MUL: begin
            cmd.op   = OP_MUL;
            state_in = ST_RCP;
         end
         ST_RCP: begin
            cmd.op   = OP_RCP;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            cmd.op   = OP_FIX;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.op = OP_ACC;
            if (status.region == REG_DIRECT) begin
               cont = !status.term_zero && (idx_ff < DIR_LAST_M1);
            end else begin
               cont = status.term_gt_thr && (idx_ff < SER_LAST_M1);
            end
            if (cont) begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_MUL;
            end else begin
               state_in = ST_EXPF;
            end
         end
         ST_EXPF: begin
            cmd.op    = (status.region == REG_DIRECT) ? OP_EXPF : OP_DIVA;
            second_in = 1'b0;
            cnt_in    = CW'(DNW - 1);
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = OP_DSTEP;
            if (cnt_ff == '0) begin
               state_in = ST_POST;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_POST: begin
            if (status.region == REG_SERIES && !second_ff) begin
               cmd.op    = OP_DIVC;
               second_in = 1'b1;
               cnt_in    = CW'(DNW - 1);
               state_in  = ST_DIV;
            end else begin
               cmd.op   = (status.region == REG_DIRECT) ? OP_FIN_DIR : OP_FIN_SER;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!valid_ff || rsp_tready) begin
               cmd.op   = OP_WRITE;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         idx_ff    <= '0;
         second_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         idx_ff    <= idx_in;
         second_ff <= second_in;
         valid_ff  <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

   // A new result never overwrites one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_WRITE) |-> (!valid_ff || rsp_tready))
      else $error("result register overwritten while stalled");

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_CLASS))
      else $error("accepted beat not classified");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff != '0) |=>
         (state_ff == ST_DIV && cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("divider step count broken");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL && status.region == REG_DIRECT) |-> (idx_ff < DIR_LAST_M1 + 5'd1))
      else $error("exponential term index out of range");

endmodule

@@ rtl/bernoulli_function_pair.sv @@
// ----------------------------------------------------------------------------
// Bernoulli function pair
// Computes B(x) = x/(exp(x)-1) and B(-x) = x + B(x) for one fixed-point x.
// ----------------------------------------------------------------------------
// One argument at a time: x = 0 and |x| > 80 go from classification to the
// result write; the direct region runs range reduction, T <= 24 exponential
// terms, one division and the write; the series region runs T <= 31 terms,
// two divisions and the write. The term loop (multiply, reciprocal multiply,
// correction, accumulate) and the one-bit-per-cycle restoring divider take
// most of the time. A finished result sits in an output register, so
// the next beat is taken while it waits. No state carries over between beats.
// ----------------------------------------------------------------------------
module bernoulli_function_pair #(
   parameter int FRAC_BITS = 16,
   parameter int INT_BITS  = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // arg (signed, INT_BITS+FRAC_BITS+1 bits), zero fill
   input  logic [((INT_BITS+FRAC_BITS+1+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // b_pos, b_neg (INT_BITS+FRAC_BITS bits each), region (2 bits), zero fill
   output logic [((2*(INT_BITS+FRAC_BITS)+2+7)/8)*8-1:0] rsp_tdata
);
   import bfp_pkg::*;

   localparam int OUT_W = INT_BITS + FRAC_BITS;
   localparam int IN_W  = OUT_W + 1;
   localparam int RSP_W = ((2 * OUT_W + 2 + 7) / 8) * 8;
   localparam int DNW   = OUT_W + 31;

   cmd_type            cmd;
   status_type         status;
   logic [OUT_W-1:0]   b_pos, b_neg;
   logic [1:0]         region;
   logic signed [IN_W-1:0] arg;

   assign arg = $signed(req_tdata[IN_W-1:0]);

   bfp_ctrl #(
      .DNW (DNW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bfp_dp #(
      .FRAC_BITS (FRAC_BITS),
      .INT_BITS  (INT_BITS)
   ) u_dp (
      .clock  (clock),
      .arg    (arg),
      .cmd    (cmd),
      .status (status),
      .b_pos  (b_pos),
      .b_neg  (b_neg),
      .region (region)
   );

   assign rsp_tdata = RSP_W'({region, b_neg, b_pos});

endmodule
